@@ sv/text_glyph_framebuffer_writer_defines.svh @@
// Assertion macros shared by the character generator modules.
`ifndef TEXT_GLYPH_FRAMEBUFFER_WRITER_DEFINES_SVH
`define TEXT_GLYPH_FRAMEBUFFER_WRITER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TGFW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TGFW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/tgfw_pkg.sv @@
`default_nettype none

package tgfw_pkg;

  // Default geometry of the panel.
  localparam int DISPLAY_WIDTH_DEF = 128;
  localparam int PAGE_COUNT_DEF    = 8;

  // Item modes.
  localparam logic [1:0] MODE_SET_POS = 2'd0;
  localparam logic [1:0] MODE_PUT     = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;
  localparam logic [1:0] MODE_READ    = 2'd3;

  // Result kinds.
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // Controller command bytes.
  localparam logic [7:0] CMD_PAGE_BASE   = 8'hB0;
  localparam logic [7:0] CMD_COL_LO_MASK = 8'h0F;
  localparam logic [7:0] CMD_COL_HI_BASE = 8'h10;

  // Character cell geometry.
  localparam logic [2:0] GLYPH_COLS   = 3'd5;
  localparam logic [2:0] CELL_ADVANCE = 3'd6;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [2:0] page;
    logic [6:0] column;
  } item_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  // Five glyph columns, column 0 in the top byte. Unknown codes are blank.
  function automatic logic [39:0] glyph_bits(input logic [7:0] code);
    logic [39:0] g;
    case (code)
      8'h2C: g = {8'h00, 8'h50, 8'h30, 8'h00, 8'h00};
      8'h2D: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      8'h2E: g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      8'h3A: g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      8'h30: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      8'h31: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      8'h32: g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      8'h33: g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      8'h34: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      8'h35: g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      8'h36: g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      8'h37: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h39: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      8'h41: g = {8'h7E, 8'h09, 8'h09, 8'h09, 8'h7E};
      8'h42: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h43: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      8'h44: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      8'h45: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      8'h46: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
      8'h47: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
      8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      8'h4A: g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
      8'h4B: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
      8'h4C: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
      8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      8'h4E: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
      8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      8'h50: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      8'h51: g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
      8'h52: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
      8'h53: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      8'h57: g = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
      8'h58: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      8'h59: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      8'h5A: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
      8'h5F: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h40};
      8'h65: g = {8'h38, 8'h54, 8'h54, 8'h54, 8'h18};
      8'h67: g = {8'h08, 8'h54, 8'h54, 8'h54, 8'h3C};
      8'h69: g = {8'h00, 8'h44, 8'h7D, 8'h40, 8'h00};
      8'h6D: g = {8'h7C, 8'h04, 8'h18, 8'h04, 8'h78};
      8'h6E: g = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h78};
      8'h6F: g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
      8'h74: g = {8'h04, 8'h3F, 8'h44, 8'h40, 8'h20};
      8'h75: g = {8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C};
      8'h71: g = {8'h08, 8'h14, 8'h14, 8'h18, 8'h7C};
      8'h72: g = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h08};
      8'h79: g = {8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C};
      8'h7A: g = {8'h44, 8'h64, 8'h54, 8'h4C, 8'h44};
      8'h25: g = {8'h62, 8'h64, 8'h08, 8'h13, 8'h23};
      default: g = '0;
    endcase
    return g;
  endfunction

  // One column of a character cell; the spacer column and beyond are blank.
  function automatic logic [7:0] glyph_column(input logic [7:0] code,
                                              input logic [2:0] idx);
    logic [39:0] g;
    logic [7:0]  b;
    g = glyph_bits(code);
    case (idx)
      3'd0:    b = g[39:32];
      3'd1:    b = g[31:24];
      3'd2:    b = g[23:16];
      3'd3:    b = g[15:8];
      3'd4:    b = g[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ sv/tgfw_store.sv @@
`default_nettype none

module tgfw_store #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int PAGE_COUNT    = 8
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic                                         re,
  input  wire logic [$clog2(PAGE_COUNT*DISPLAY_WIDTH)-1:0]  addr,
  input  wire logic [7:0]                                   wdata,
  output logic      [7:0]                                   rdata
);

  localparam int STORE_DEPTH = PAGE_COUNT * DISPLAY_WIDTH;

  logic [7:0] mem [STORE_DEPTH];

  // Single-port frame store; read data is registered and holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/tgfw_obuf.sv @@
`default_nettype none
`include "text_glyph_framebuffer_writer_defines.svh"

module tgfw_obuf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tgfw_pkg::result_t beat,
  output logic                  ready,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output tgfw_pkg::result_t     result
);

  import tgfw_pkg::*;

  // The register can take a beat when empty or when its beat leaves now.
  assign ready = !result_valid || !result_stall;

  // Output register between the sequencer and the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      result <= beat;
    end
  end

  `TGFW_ASSERT_NOW(a_no_overwrite, push, ready, "beat pushed over a held beat")
  `TGFW_ASSERT_NEXT(a_push_shows, push, result_valid && (result == $past(beat)), "pushed beat lost")
  `TGFW_ASSERT_NEXT(a_stall_holds, result_valid && result_stall, result_valid, "stalled beat dropped")

endmodule

`default_nettype wire

@@ sv/tgfw_ctrl.sv @@
`default_nettype none
`include "text_glyph_framebuffer_writer_defines.svh"

module tgfw_ctrl #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int PAGE_COUNT    = 8
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        item_valid,
  output logic                                             item_stall,
  input  wire tgfw_pkg::item_t                             item,
  input  wire logic                                        obuf_ready,
  output logic                                             push,
  output tgfw_pkg::result_t                                beat,
  output logic                                             mem_we,
  output logic                                             mem_re,
  output logic [$clog2(PAGE_COUNT*DISPLAY_WIDTH)-1:0]      mem_addr,
  output logic [7:0]                                       mem_wdata,
  input  wire logic [7:0]                                  mem_rdata
);

  import tgfw_pkg::*;

  localparam int         STORE_DEPTH = PAGE_COUNT * DISPLAY_WIDTH;
  localparam int         AW          = $clog2(STORE_DEPTH);
  localparam logic [3:0] PAGE_LIMIT  = 4'(PAGE_COUNT);
  localparam logic [7:0] COL_LIMIT   = 8'(DISPLAY_WIDTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CMD,
    S_WRITE,
    S_READ
  } state_t;

  state_t      state;
  logic [2:0]  cursor_row;
  logic [7:0]  cursor_col;
  logic [AW-1:0] clr_addr;
  logic [2:0]  cnt;
  logic [7:0]  code;
  logic [2:0]  cmd_page;
  logic [6:0]  cmd_col;
  logic        rd_oob;

  logic        accept;
  logic        cursor_on;
  logic        rd_in_range;
  logic [7:0]  wcol;

  // Page and column to a store address.
  function automatic logic [AW-1:0] store_addr(input logic [2:0] row,
                                               input logic [7:0] col);
    logic [10:0] full;
    full = 11'(row) * 11'(DISPLAY_WIDTH) + 11'(col);
    return full[AW-1:0];
  endfunction

  assign item_stall  = (state != S_IDLE);
  assign accept      = item_valid && (state == S_IDLE);
  assign cursor_on   = ({1'b0, cursor_row} < PAGE_LIMIT) && (cursor_col < COL_LIMIT);
  assign rd_in_range = ({1'b0, item.page} < PAGE_LIMIT) && ({1'b0, item.column} < COL_LIMIT);
  assign wcol        = cursor_col + {5'd0, cnt};

  // Store accesses and result beats for the current step.
  always_comb begin
    push      = 1'b0;
    beat      = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      S_IDLE: begin
        if (accept && item.mode == MODE_READ && rd_in_range) begin
          mem_re   = 1'b1;
          mem_addr = store_addr(item.page, {1'b0, item.column});
        end
      end
      S_CMD: begin
        push = obuf_ready;
        beat.out_kind = KIND_CMD;
        case (cnt)
          3'd0:    beat.out_byte = CMD_PAGE_BASE | {5'd0, cmd_page};
          3'd1:    beat.out_byte = {1'b0, cmd_col} & CMD_COL_LO_MASK;
          default: beat.out_byte = CMD_COL_HI_BASE | {5'd0, cmd_col[6:4]};
        endcase
        beat.last = (cnt == 3'd2);
      end
      S_WRITE: begin
        if (wcol < COL_LIMIT) begin
          mem_we    = 1'b1;
          mem_addr  = store_addr(cursor_row, wcol);
          mem_wdata = glyph_column(code, cnt);
        end
      end
      S_READ: begin
        push          = obuf_ready;
        beat.out_kind = KIND_DATA;
        beat.out_byte = rd_oob ? 8'h00 : mem_rdata;
        beat.last     = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Sequencer: clearing pass, command beats, cell writes and reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      cursor_row <= '0;
      cursor_col <= '0;
      cnt        <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
          clr_addr <= clr_addr + 1'b1;
        end
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            case (item.mode)
              MODE_SET_POS: begin
                cursor_row <= item.page;
                cursor_col <= {1'b0, item.column};
                cmd_page   <= item.page;
                cmd_col    <= item.column;
                state      <= S_CMD;
              end
              MODE_PUT: begin
                code <= item.char_code;
                if (cursor_on) begin
                  state <= S_WRITE;
                end
              end
              MODE_CLEAR: begin
                cursor_row <= '0;
                cursor_col <= '0;
                clr_addr   <= '0;
                state      <= S_CLEAR;
              end
              default: begin
                rd_oob <= !rd_in_range;
                state  <= S_READ;
              end
            endcase
          end
        end
        S_CMD: begin
          if (push) begin
            cnt <= cnt + 3'd1;
            if (cnt == 3'd2) begin
              state <= S_IDLE;
            end
          end
        end
        S_WRITE: begin
          cnt <= cnt + 3'd1;
          if (cnt == CELL_ADVANCE - 3'd1) begin
            cursor_col <= cursor_col + {5'd0, CELL_ADVANCE};
            state      <= S_IDLE;
          end
        end
        S_READ: begin
          if (push) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TGFW_ASSERT_NOW(a_single_port, mem_we || mem_re, !(mem_we && mem_re), "store read and written together")
  `TGFW_ASSERT_NEXT(a_cmd_done, (state == S_CMD) && push && beat.last, state == S_IDLE, "command sequence did not end")
  `TGFW_ASSERT_NEXT(a_cursor_held, (state == S_CMD) || (state == S_READ) || (state == S_CLEAR), $stable(cursor_col) && $stable(cursor_row), "cursor moved mid-item")
  `TGFW_ASSERT_NOW(a_write_on_screen, (state == S_WRITE) && mem_we, cursor_on && (wcol < COL_LIMIT), "glyph write off screen")

endmodule

`default_nettype wire

@@ sv/text_glyph_framebuffer_writer.sv @@
`default_nettype none

// Character generator for a page-organized monochrome frame store of
// PAGE_COUNT pages by DISPLAY_WIDTH column bytes (bit 0 is the top row).
// One item is worked at a time by a sequencer around a single-port store
// with registered read data. Set position sends three command beats, put
// character writes six column bytes (five glyph columns and a blank
// spacer, clipped at the right edge), read hands the registered store byte
// to the output register as its data beat, and clear walks the store
// writing one zero per cycle. The same clearing pass runs after reset, and
// item_stall stays high until it ends. Result beats pass through an output
// register, so the next item can be taken while the last beat of the
// previous one still waits on result_stall.
module text_glyph_framebuffer_writer #(
  parameter int DISPLAY_WIDTH = tgfw_pkg::DISPLAY_WIDTH_DEF,
  parameter int PAGE_COUNT    = tgfw_pkg::PAGE_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire tgfw_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output tgfw_pkg::result_t      result
);

  import tgfw_pkg::*;

  localparam int AW = $clog2(PAGE_COUNT * DISPLAY_WIDTH);

  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;
  logic          push;
  logic          obuf_ready;
  result_t       beat;

  // Sequencer.
  tgfw_ctrl #(
    .DISPLAY_WIDTH(DISPLAY_WIDTH),
    .PAGE_COUNT   (PAGE_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .obuf_ready (obuf_ready),
    .push       (push),
    .beat       (beat),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  // Frame store.
  tgfw_store #(
    .DISPLAY_WIDTH(DISPLAY_WIDTH),
    .PAGE_COUNT   (PAGE_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Result register.
  tgfw_obuf u_obuf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .beat         (beat),
    .ready        (obuf_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tgfw_pkg::*;

  localparam int PANEL_W      = DISPLAY_WIDTH_DEF;
  localparam int PANEL_PAGES  = PAGE_COUNT_DEF;
  localparam int STORE_BYTES  = 1024;
  localparam int RANDOM_ITEMS = 255;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE_CYCLES = 40;

  // Tracks the frame store and cursor, and holds the bytes the block owes us.
  class text_pane_tracker;
    logic [7:0] font [0:255][0:4];
    logic [7:0] pixels [0:STORE_BYTES-1];
    logic [2:0] row;
    logic [7:0] col;
    result_t    owed_bytes [$];
    int unsigned faults;

    function new();
      foreach (font[c, k]) font[c][k] = 8'h00;
      foreach (pixels[i]) pixels[i] = 8'h00;
      row = '0;
      col = '0;
      faults = 0;
      load_glyph(",", 40'h00_50_30_00_00);
      load_glyph("-", 40'h08_08_08_08_08);
      load_glyph(".", 40'h00_60_60_00_00);
      load_glyph(":", 40'h00_36_36_00_00);
      load_glyph("0", 40'h3E_51_49_45_3E);
      load_glyph("1", 40'h00_42_7F_40_00);
      load_glyph("2", 40'h42_61_51_49_46);
      load_glyph("3", 40'h21_41_45_4B_31);
      load_glyph("4", 40'h18_14_12_7F_10);
      load_glyph("5", 40'h27_45_45_45_39);
      load_glyph("6", 40'h3C_4A_49_49_30);
      load_glyph("7", 40'h01_71_09_05_03);
      load_glyph("8", 40'h36_49_49_49_36);
      load_glyph("9", 40'h06_49_49_29_1E);
      load_glyph("A", 40'h7E_09_09_09_7E);
      load_glyph("B", 40'h7F_49_49_49_36);
      load_glyph("C", 40'h3E_41_41_41_22);
      load_glyph("D", 40'h7F_41_41_22_1C);
      load_glyph("E", 40'h7F_49_49_49_41);
      load_glyph("F", 40'h7F_09_09_09_01);
      load_glyph("G", 40'h3E_41_49_49_7A);
      load_glyph("H", 40'h7F_08_08_08_7F);
      load_glyph("I", 40'h00_41_7F_41_00);
      load_glyph("J", 40'h20_40_41_3F_01);
      load_glyph("K", 40'h7F_08_14_22_41);
      load_glyph("L", 40'h7F_40_40_40_40);
      load_glyph("M", 40'h7F_02_0C_02_7F);
      load_glyph("N", 40'h7F_04_08_10_7F);
      load_glyph("O", 40'h3E_41_41_41_3E);
      load_glyph("P", 40'h7F_09_09_09_06);
      load_glyph("Q", 40'h3E_41_51_21_5E);
      load_glyph("R", 40'h7F_09_19_29_46);
      load_glyph("S", 40'h46_49_49_49_31);
      load_glyph("T", 40'h01_01_7F_01_01);
      load_glyph("U", 40'h3F_40_40_40_3F);
      load_glyph("V", 40'h1F_20_40_20_1F);
      load_glyph("W", 40'h7F_20_18_20_7F);
      load_glyph("X", 40'h63_14_08_14_63);
      load_glyph("Y", 40'h07_08_70_08_07);
      load_glyph("Z", 40'h61_51_49_45_43);
      load_glyph("_", 40'h40_40_40_40_40);
      load_glyph("e", 40'h38_54_54_54_18);
      load_glyph("g", 40'h08_54_54_54_3C);
      load_glyph("i", 40'h00_44_7D_40_00);
      load_glyph("m", 40'h7C_04_18_04_78);
      load_glyph("n", 40'h7C_08_04_04_78);
      load_glyph("o", 40'h38_44_44_44_38);
      load_glyph("t", 40'h04_3F_44_40_20);
      load_glyph("u", 40'h3C_40_40_20_7C);
      load_glyph("q", 40'h08_14_14_18_7C);
      load_glyph("r", 40'h7C_08_04_04_08);
      load_glyph("y", 40'h0C_50_50_50_3C);
      load_glyph("z", 40'h44_64_54_4C_44);
      load_glyph("%", 40'h62_64_08_13_23);
    endfunction

    // Column 0 of the glyph sits in the top byte of the packed word.
    function void load_glyph(logic [7:0] code, logic [39:0] cols);
      for (int k = 0; k < 5; k++) font[code][k] = cols[39-8*k -: 8];
    endfunction

    function void owe(logic kind, logic [7:0] value, logic tail);
      result_t r;
      r.out_kind = kind;
      r.out_byte = value;
      r.last     = tail;
      owed_bytes.push_back(r);
    endfunction

    function int slot(int pg, int c);
      return (pg * PANEL_W + c) & (STORE_BYTES - 1);
    endfunction

    // Applies one accepted item to the shadow state.
    function void take_item(item_t it);
      int c;
      case (it.mode)
        MODE_SET_POS: begin
          row = it.page;
          col = {1'b0, it.column};
          owe(KIND_CMD, CMD_PAGE_BASE | {5'b0, it.page}, 1'b0);
          owe(KIND_CMD, CMD_COL_LO_MASK & {1'b0, it.column}, 1'b0);
          owe(KIND_CMD, CMD_COL_HI_BASE | {5'b0, it.column[6:4]}, 1'b1);
        end
        MODE_PUT: begin
          // An off-screen cursor leaves everything untouched.
          if (int'(row) < PANEL_PAGES && int'(col) < PANEL_W) begin
            for (int k = 0; k < int'(CELL_ADVANCE); k++) begin
              c = int'(col) + k;
              if (c < PANEL_W)
                pixels[slot(row, c)] = (k < int'(GLYPH_COLS)) ? font[it.char_code][k] : 8'h00;
            end
            col = col + 8'(CELL_ADVANCE);
          end
        end
        MODE_CLEAR: begin
          foreach (pixels[i]) pixels[i] = 8'h00;
          row = '0;
          col = '0;
        end
        MODE_READ: begin
          if (int'(it.page) < PANEL_PAGES && int'(it.column) < PANEL_W)
            owe(KIND_DATA, pixels[slot(it.page, it.column)], 1'b1);
          else
            owe(KIND_DATA, 8'h00, 1'b1);
        end
        default: ;
      endcase
    endfunction

    // Compares one accepted result beat with the oldest owed byte.
    function void match_result(result_t got);
      result_t want;
      if (owed_bytes.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("tb: unexpected result kind=%0d byte=%02h last=%0d",
                   got.out_kind, got.out_byte, got.last);
      end else begin
        want = owed_bytes.pop_front();
        if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
            got.last !== want.last) begin
          faults++;
          if (faults <= 10)
            $display("tb: mismatch expected kind=%0d byte=%02h last=%0d,",
                     want.out_kind, want.out_byte, want.last,
                     " got kind=%0d byte=%02h last=%0d",
                     got.out_kind, got.out_byte, got.last);
        end
      end
    endfunction
  endclass

  logic    clk;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  text_pane_tracker book = new();
  string glyph_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ_egimnotuqryz%,-.: ";
  int    items_sent = 0;
  int    burst_left = 0;
  int    cycles = 0;

  text_glyph_framebuffer_writer uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch both channels at the rising edge and bound the run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (item_valid && !item_stall) book.take_item(item);
      if (result_valid && !result_stall) book.match_result(result);
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Result stall pattern: free-running, light, heavy, or long on/off holds.
  int   stall_style = 0;
  int   stall_phase = 0;
  int   hold_left = 0;
  logic hold_on = 1'b0;
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_phase = $urandom_range(20, 80);
    end
    stall_phase = stall_phase - 1;
    case (stall_style)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 9) < 3);
      2: result_stall <= ($urandom_range(0, 9) < 8);
      default: begin
        if (hold_left == 0) begin
          hold_on = ~hold_on;
          hold_left = $urandom_range(1, 12);
        end
        hold_left = hold_left - 1;
        result_stall <= hold_on;
      end
    endcase
  end

  // Drives one item from a falling edge and returns at the falling edge after
  // it was taken. Items go out in bursts, usually with idle gaps between them.
  task automatic send_item(logic [1:0] mode, logic [7:0] code, logic [2:0] pg,
                           logic [6:0] column);
    item_t it;
    int    gap;
    it.mode      = mode;
    it.char_code = code;
    it.page      = pg;
    it.column    = column;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left = burst_left - 1;
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    items_sent++;
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
  endfunction

  // A well-formed text line: place the cursor, write a few characters, then
  // read back bytes around them.
  task automatic write_line();
    logic [2:0] pg;
    logic [6:0] start;
    logic [6:0] at;
    int         chars;
    int         reads;
    pg = 3'($urandom);
    case ($urandom_range(0, 3))
      0: start = 7'($urandom);
      1: start = 7'($urandom_range(110, 127));
      2: start = 7'($urandom_range(0, 20));
      default: start = 7'(6 * $urandom_range(0, 21));
    endcase
    send_item(MODE_SET_POS, 8'($urandom), pg, start);
    chars = $urandom_range(1, 8);
    repeat (chars) send_item(MODE_PUT, pick_char(), 3'($urandom), 7'($urandom));
    reads = $urandom_range(1, 6);
    repeat (reads) begin
      at = start + 7'($urandom_range(0, 6 * chars + 2));
      if ($urandom_range(0, 4) == 0)
        send_item(MODE_READ, 8'($urandom), 3'($urandom), 7'($urandom));
      else
        send_item(MODE_READ, 8'($urandom), pg, at);
    end
  endtask

  initial begin
    item_t noise;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reads of a fresh store, corners, clipping, blank codes, clear.
    send_item(MODE_READ, 8'h00, 3'd0, 7'd0);
    send_item(MODE_READ, 8'hFF, 3'd7, 7'd127);
    send_item(MODE_SET_POS, 8'h00, 3'd0, 7'd0);
    send_item(MODE_PUT, "A", 3'd0, 7'd0);
    send_item(MODE_PUT, 8'h00, 3'd0, 7'd0);
    send_item(MODE_PUT, 8'hFF, 3'd7, 7'd127);
    send_item(MODE_READ, 8'h00, 3'd0, 7'd0);
    send_item(MODE_READ, 8'h00, 3'd0, 7'd5);
    send_item(MODE_SET_POS, 8'hFF, 3'd7, 7'd127);
    // Right edge: only the first column of the cell lands, cursor runs off.
    send_item(MODE_PUT, "8", 3'd0, 7'd0);
    send_item(MODE_PUT, "0", 3'd0, 7'd0);
    send_item(MODE_READ, 8'h00, 3'd7, 7'd127);
    send_item(MODE_READ, 8'h00, 3'd7, 7'd126);
    send_item(MODE_SET_POS, 8'h00, 3'd3, 7'd122);
    send_item(MODE_PUT, "W", 3'd0, 7'd0);
    send_item(MODE_READ, 8'h00, 3'd3, 7'd126);
    send_item(MODE_READ, 8'h00, 3'd3, 7'd127);
    send_item(MODE_SET_POS, 8'h00, 3'd5, 7'h55);
    send_item(MODE_PUT, "%", 3'd0, 7'd0);
    send_item(MODE_READ, 8'h00, 3'd5, 7'h58);
    send_item(MODE_CLEAR, 8'h00, 3'd0, 7'd0);
    send_item(MODE_READ, 8'h00, 3'd3, 7'd122);
    send_item(MODE_PUT, "1", 3'd0, 7'd0);
    send_item(MODE_READ, 8'h00, 3'd0, 7'd2);

    // Random: mostly text lines, some clears and raw noise.
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 99)) inside
        [0:79]: write_line();
        [80:87]: send_item(MODE_CLEAR, 8'($urandom), 3'($urandom), 7'($urandom));
        default: begin
          noise = item_t'($urandom);
          send_item(noise.mode, noise.char_code, noise.page, noise.column);
        end
      endcase
    end
    item_valid <= 1'b0;

    // Drain owed bytes, then give the block time to show anything extra.
    while (book.owed_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.faults == 0 && book.owed_bytes.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/tgfw_pkg.sv
sv/tgfw_store.sv
sv/tgfw_obuf.sv
sv/tgfw_ctrl.sv
sv/text_glyph_framebuffer_writer.sv
dv/tb.sv
